### sv/klv_timestamp_extractor_defines.svh
// Assertion helpers shared by the extractor modules.
`ifndef KLV_TIMESTAMP_EXTRACTOR_DEFINES_SVH
`define KLV_TIMESTAMP_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define KLVTS_ASSERT_IMPLY(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("klvts: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define KLVTS_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("klvts: next-cycle check failed");

`endif

### sv/klvts_pkg.sv
package klvts_pkg;

  // One byte of the local set value field.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } klvts_in_t;

  // Per-packet report.
  typedef struct packed {
    logic [63:0] timestamp;
    logic        found;
  } klvts_out_t;

  localparam logic [7:0] TAG_RESET = 8'd2;

  // Walker phase codes; code 3 is unused and behaves as PH_TAG.
  localparam logic [1:0] PH_TAG = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_VAL = 2'd2;

endpackage

### sv/klvts_walker.sv
`include "klv_timestamp_extractor_defines.svh"

module klvts_walker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  klvts_pkg::klvts_in_t   item,
  input  logic [7:0]             tag,
  output klvts_pkg::klvts_out_t  result
);
  import klvts_pkg::*;

  logic [1:0]  phase;
  logic [7:0]  bytes_left;
  logic        in_match;
  logic [63:0] accumulator;
  logic        match_seen;
  logic        match_done;

  logic [1:0]  phase_next;
  logic [7:0]  bytes_left_next;
  logic        in_match_next;
  logic [63:0] accumulator_next;
  logic        match_seen_next;
  logic        match_done_next;
  logic [7:0]  left_dec;

  assign left_dec = bytes_left - 8'd1;

  // Advance the tag/length/value walk by one byte.
  always_comb begin
    phase_next       = phase;
    bytes_left_next  = bytes_left;
    in_match_next    = in_match;
    accumulator_next = accumulator;
    match_seen_next  = match_seen;
    match_done_next  = match_done;
    unique case (phase)
      PH_LEN: begin
        bytes_left_next = item.data_byte;
        if (item.data_byte == 8'd0) begin
          phase_next = PH_TAG;
          if (in_match) begin
            match_done_next = 1'b1;
            in_match_next   = 1'b0;
          end
        end else begin
          phase_next = PH_VAL;
        end
      end
      PH_VAL: begin
        if (in_match) begin
          accumulator_next = {accumulator[55:0], item.data_byte};
        end
        bytes_left_next = left_dec;
        if (left_dec == 8'd0) begin
          phase_next = PH_TAG;
          if (in_match) begin
            match_done_next = 1'b1;
            in_match_next   = 1'b0;
          end
        end
      end
      default: begin
        if (!match_seen && !match_done && item.data_byte == tag) begin
          in_match_next   = 1'b1;
          match_seen_next = 1'b1;
        end
        phase_next = PH_LEN;
      end
    endcase
  end

  // Report reflects the state after this byte.
  assign result.found     = match_seen_next;
  assign result.timestamp = match_seen_next ? accumulator_next : 64'd0;

  // Hold state between transfers; clear packet state after the last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TAG;
      bytes_left  <= 8'd0;
      in_match    <= 1'b0;
      accumulator <= 64'd0;
      match_seen  <= 1'b0;
      match_done  <= 1'b0;
    end else if (accept) begin
      if (item.last_byte) begin
        phase       <= PH_TAG;
        bytes_left  <= 8'd0;
        in_match    <= 1'b0;
        accumulator <= 64'd0;
        match_seen  <= 1'b0;
        match_done  <= 1'b0;
      end else begin
        phase       <= phase_next;
        bytes_left  <= bytes_left_next;
        in_match    <= in_match_next;
        accumulator <= accumulator_next;
        match_seen  <= match_seen_next;
        match_done  <= match_done_next;
      end
    end
  end

  `KLVTS_ASSERT_IMPLY(a_match_flags, clk, rst, in_match, match_seen && !match_done)
  `KLVTS_ASSERT_IMPLY(a_done_seen, clk, rst, match_done, match_seen)
  `KLVTS_ASSERT_IMPLY(a_match_phase, clk, rst, in_match, phase == PH_LEN || phase == PH_VAL)

endmodule

### sv/klv_timestamp_extractor.sv
// The report for a packet is valid in the cycle after its last byte transfers.
// Throughput: one byte per cycle; the single-stage walker and output register set it.
// Bytes without the last mark never stall; a last byte stalls only while a report waits.
// Reset (rst, synchronous, active high) clears the walk state and the output valid,
// and returns the timestamp tag to 2.
`include "klv_timestamp_extractor_defines.svh"

module klv_timestamp_extractor (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  klvts_pkg::klvts_in_t   byte_data,
  output logic                   result_valid,
  input  logic                   result_stall,
  output klvts_pkg::klvts_out_t  result_data,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_wdata
);
  import klvts_pkg::*;

  logic       accept;
  logic [7:0] tag;
  klvts_out_t walk_result;

  // Stall a packet end only while the previous report is held.
  assign byte_stall = byte_data.last_byte && result_valid && result_stall;
  assign accept     = byte_valid && !byte_stall;

  // Hold the configured tag.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= TAG_RESET;
    end else if (cfg_we) begin
      tag <= cfg_wdata;
    end
  end

  klvts_walker u_walker (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (byte_data),
    .tag    (tag),
    .result (walk_result)
  );

  // Output register: load on a packet end, drop after the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && byte_data.last_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_data.last_byte) begin
      result_data <= walk_result;
    end
  end

  `KLVTS_ASSERT_IMPLY(a_stall_cause, clk, rst, byte_stall, result_valid && result_stall)
  `KLVTS_ASSERT_NEXT(a_end_reports, clk, rst, accept && byte_data.last_byte, result_valid)
  `KLVTS_ASSERT_NEXT(a_drain, clk, rst, result_valid && !result_stall && !(accept && byte_data.last_byte), !result_valid)
  `KLVTS_ASSERT_IMPLY(a_zero_miss, clk, rst, result_valid && !result_data.found, result_data.timestamp == 64'd0)

endmodule

### tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import klvts_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 160;
  localparam int DRAIN_CYCLES   = 8;

  logic       clk;
  logic       rst;
  logic       byte_valid;
  logic       byte_stall;
  klvts_in_t  byte_data;
  logic       result_valid;
  logic       result_stall;
  klvts_out_t result_data;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  klv_timestamp_extractor u_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // Directed packets; reports are typed in where they are obvious.
  typedef struct {
    logic [7:0]  byte_val;
    logic        is_last;
    bit          typed;
    logic [63:0] ts;
    logic        fnd;
  } walk_row_t;

  walk_row_t walk_rows [26] = '{
    // matching tag as the only byte
    '{8'h02, 1'b1, 1'b1, 64'h0, 1'b1},
    // no match at all
    '{8'h05, 1'b1, 1'b1, 64'h0, 1'b0},
    // full 8-byte timestamp
    '{8'h02, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h08, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h23, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h45, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h67, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h89, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'hAB, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'hCD, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'hEF, 1'b1, 1'b1, 64'h0123456789ABCDEF, 1'b1},
    // zero-length match, then a later match that must be skipped
    '{8'h02, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h02, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 64'h0, 1'b1},
    // other item first, then a match cut short by the packet end
    '{8'h07, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'hAA, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h02, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h03, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 64'h000000000000FFFF, 1'b1},
    // length byte closes the packet
    '{8'h02, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h04, 1'b1, 1'b1, 64'h0, 1'b1}
  };

  // Walker copy used for prediction
  logic [7:0]  ts_tag;
  logic [1:0]  walk_phase;
  logic [7:0]  value_left;
  bit          in_ts_item;
  bit          ts_seen;
  bit          ts_done;
  logic [63:0] ts_acc;

  klvts_out_t ts_expected [$];
  klvts_in_t  pkt_bytes [$];

  int fail_count  = 0;
  int idle_cycles = 0;
  int idle_pct;
  int stall_pct;
  bit hold_req;

  function automatic void clear_walk();
    walk_phase = PH_TAG;
    value_left = '0;
    in_ts_item = 1'b0;
    ts_acc     = '0;
    ts_seen    = 1'b0;
    ts_done    = 1'b0;
  endfunction

  function automatic void close_item();
    walk_phase = PH_TAG;
    value_left = '0;
    if (in_ts_item) begin
      ts_done    = 1'b1;
      in_ts_item = 1'b0;
    end
  endfunction

  // Advance the walk by one byte; return 1 when the packet report is due.
  function automatic bit walk_byte(input klvts_in_t b, output klvts_out_t rpt);
    rpt = '0;
    if (walk_phase == PH_LEN) begin
      value_left = b.data_byte;
      if (b.data_byte == 8'd0) close_item();
      else walk_phase = PH_VAL;
    end else if (walk_phase == PH_VAL) begin
      if (in_ts_item) ts_acc = {ts_acc[55:0], b.data_byte};
      value_left = value_left - 8'd1;
      if (value_left == 8'd0) close_item();
    end else begin
      if (!ts_seen && !ts_done && b.data_byte == ts_tag) begin
        in_ts_item = 1'b1;
        ts_seen    = 1'b1;
      end
      walk_phase = PH_LEN;
    end
    if (!b.last_byte) return 1'b0;
    rpt.timestamp = ts_seen ? ts_acc : 64'd0;
    rpt.found     = ts_seen;
    clear_walk();
    return 1'b1;
  endfunction

  // Offer one byte, hold it until the transfer, then predict.
  task automatic send_byte(input klvts_in_t item, input bit typed,
                           input klvts_out_t typed_rpt);
    klvts_out_t rpt;
    while ($urandom_range(99) < idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= item;
    do @(posedge clk); while (byte_stall);
    if (walk_byte(item, rpt)) ts_expected.push_back(typed ? typed_rpt : rpt);
  endtask

  // Drain the block, then change the timestamp tag.
  task automatic write_tag(input logic [7:0] tag);
    byte_valid <= 1'b0;
    while (ts_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= tag;
    @(posedge clk);
    ts_tag = tag;
    cfg_we <= 1'b0;
  endtask

  // Build one packet: mostly well-formed item chains, some noise or truncation.
  task automatic make_packet();
    int         n_items;
    int         len;
    int         cut;
    logic [7:0] tag;
    pkt_bytes.delete();
    if ($urandom_range(9) < 2) begin
      len = $urandom_range(20, 1);
      repeat (len) pkt_bytes.push_back({8'($urandom), 1'b0});
    end else begin
      n_items = $urandom_range(3, 1);
      repeat (n_items) begin
        tag = ($urandom_range(2) == 0) ? ts_tag : 8'($urandom);
        case ($urandom_range(39))
          0:         len = $urandom_range(255, 13);
          1, 2, 3:   len = $urandom_range(12, 9);
          4, 5, 6:   len = 0;
          default:   len = $urandom_range(8, 1);
        endcase
        pkt_bytes.push_back({tag, 1'b0});
        pkt_bytes.push_back({8'(len), 1'b0});
        repeat (len) pkt_bytes.push_back({8'($urandom), 1'b0});
      end
      if ($urandom_range(9) == 0) begin
        cut = $urandom_range(pkt_bytes.size(), 1);
        while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
      end
    end
    pkt_bytes[pkt_bytes.size() - 1].last_byte = 1'b1;
  endtask

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin : receiver
    bit hold_taken;
    hold_taken   = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each report transfer with the oldest prediction.
  always @(posedge clk) begin : check_reports
    klvts_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (ts_expected.size() == 0) begin
        $display("%0t: unexpected report: expected none, got timestamp %h found %b",
                 $time, result_data.timestamp, result_data.found);
        fail_count++;
      end else begin
        want = ts_expected.pop_front();
        if (result_data.timestamp !== want.timestamp) begin
          $display("%0t: timestamp mismatch: expected %h, got %h",
                   $time, want.timestamp, result_data.timestamp);
          fail_count++;
        end
        if (result_data.found !== want.found) begin
          $display("%0t: found mismatch: expected %b, got %b",
                   $time, want.found, result_data.found);
          fail_count++;
        end
      end
    end
  end

  // Stop the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    klvts_out_t typed_rpt;
    logic [7:0] phase_tags [5];
    int         sent;
    rst        = 1'b1;
    byte_valid = 1'b0;
    byte_data  = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    idle_pct   = 34;
    stall_pct  = 34;
    hold_req   = 1'b0;
    ts_tag     = TAG_RESET;
    clear_walk();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed packets under the reset tag
    foreach (walk_rows[i]) begin
      typed_rpt = {walk_rows[i].ts, walk_rows[i].fnd};
      send_byte({walk_rows[i].byte_val, walk_rows[i].is_last}, walk_rows[i].typed, typed_rpt);
    end

    // Random packets under several tags, extremes first
    phase_tags = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), TAG_RESET};
    foreach (phase_tags[p]) begin
      write_tag(phase_tags[p]);
      idle_pct  = (p == 1) ? 0 : 34;
      stall_pct = (p == 1) ? 0 : 34;
      if (p == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        make_packet();
        foreach (pkt_bytes[k]) send_byte(pkt_bytes[k], 1'b0, '0);
        sent += pkt_bytes.size();
      end
    end

    byte_valid <= 1'b0;
    while (ts_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### klv_timestamp_extractor.f
+incdir+sv
sv/klvts_pkg.sv
sv/klvts_walker.sv
sv/klv_timestamp_extractor.sv
tb/sv/testbench.sv
